>>> sv/caldate_pkg.sv
// Shared types, codes and calendar helpers for the calendar date counter.
// No dependencies; every other file except caldate_if imports this package.
package caldate_pkg;

  localparam logic [13:0] YEAR_MAX  = 14'd9999;
  localparam logic [3:0]  MONTH_MAX = 4'd12;
  localparam logic [3:0]  MONTH_MIN = 4'd1;
  localparam logic [4:0]  DAY_MIN   = 5'd1;
  localparam logic [4:0]  DAY_MAX   = 5'd31;

  // Reciprocal of 25 scaled by 2^17; exact quotient for every 14-bit year.
  localparam logic [12:0] RECIP_25  = 13'd5243;
  localparam int          RECIP_SH  = 17;

  typedef enum logic [1:0] {
    OP_QUERY = 2'd0,
    OP_LOAD  = 2'd1,
    OP_NEXT  = 2'd2,
    OP_PREV  = 2'd3
  } caldate_op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_WRAP    = 2'd1,
    ST_INVALID = 2'd2
  } caldate_status_t;

  typedef struct packed {
    caldate_op_t op;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } caldate_item_t;

  typedef struct packed {
    logic [13:0]     year;
    logic [3:0]      month;
    logic [4:0]      day;
    logic            leap;
    caldate_status_t status;
  } caldate_result_t;

  // Leap year by the 400/100/4 rule. A multiple of 25 is a leap year only
  // when its quotient by 25 is a multiple of 16; otherwise test y mod 4.
  function automatic logic is_leap(input logic [13:0] y);
    logic [26:0] prod;
    logic [9:0]  q;
    logic [14:0] back;
    prod = 27'(y) * 27'(RECIP_25);
    q    = prod[RECIP_SH +: 10];
    back = {1'b0, q, 4'b0000} + {2'b00, q, 3'b000} + {5'b00000, q};
    if (back == {1'b0, y}) begin
      return (q[3:0] == 4'd0);
    end else begin
      return (y[1:0] == 2'd0);
    end
  endfunction

  // Days in a month; zero for a month code that names no month.
  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    return 5'd30;
      4'd2:                                       return leap ? 5'd29 : 5'd28;
      default:                                    return 5'd0;
    endcase
  endfunction

endpackage

>>> sv/caldate_if.sv
// Valid/ready channel interfaces for command items and result items.
// Depends on nothing; the fields carry the block's item fields under their own names.
interface caldate_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [13:0] load_year;
  logic [3:0]  load_month;
  logic [4:0]  load_day;

  modport source (output valid, output operation, output load_year,
                  output load_month, output load_day, input ready);
  modport sink   (input valid, input operation, input load_year,
                  input load_month, input load_day, output ready);
endinterface

interface caldate_out_if;
  logic        valid;
  logic        ready;
  logic [13:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;
  logic        leap_flag;
  logic [1:0]  status;

  modport source (output valid, output out_year, output out_month, output out_day,
                  output leap_flag, output status, input ready);
  modport sink   (input valid, input out_year, input out_month, input out_day,
                  input leap_flag, input status, output ready);
endinterface

>>> sv/caldate_in_reg.sv
// Input register stage: captures one command transfer and holds it.
// Depends on caldate_pkg and caldate_in_if.
module caldate_in_reg
  import caldate_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  caldate_in_if.sink    cmd,
  input  logic          take,
  output logic          item_valid,
  output caldate_item_t item
);

  assign cmd.ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (cmd.ready) begin
      item_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      item.op    <= caldate_op_t'(cmd.operation);
      item.year  <= cmd.load_year;
      item.month <= cmd.load_month;
      item.day   <= cmd.load_day;
    end
  end

endmodule

>>> sv/caldate_core.sv
// Held date registers and the update logic for a command.
// Depends on caldate_pkg (leap and month-length helpers, codes).
module caldate_core
  import caldate_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  caldate_item_t   item,
  output caldate_result_t result
);

  logic [13:0] cur_year;
  logic [3:0]  cur_month;
  logic [4:0]  cur_day;
  logic        cur_leap;

  logic [13:0] year_inc, year_dec;
  logic        leap_inc, leap_dec, leap_load;
  logic [4:0]  len_cur, len_prev, len_load;
  logic [3:0]  month_prev;
  logic        load_bad;

  always_comb begin
    year_inc   = (cur_year >= YEAR_MAX) ? 14'd0 : cur_year + 14'd1;
    year_dec   = (cur_year == 14'd0) ? YEAR_MAX : cur_year - 14'd1;
    leap_inc   = is_leap(year_inc);
    leap_dec   = is_leap(year_dec);
    leap_load  = is_leap(item.year);
    month_prev = cur_month - 4'd1;
    len_cur    = month_len(cur_leap, cur_month);
    len_prev   = month_len(cur_leap, month_prev);
    len_load   = month_len(leap_load, item.month);
    load_bad   = (item.year > YEAR_MAX) || (len_load == 5'd0) ||
                 (item.day == 5'd0) || (item.day > len_load);
  end

  always_comb begin
    result.year   = cur_year;
    result.month  = cur_month;
    result.day    = cur_day;
    result.leap   = cur_leap;
    result.status = ST_OK;
    case (item.op)
      OP_QUERY: begin
      end
      OP_LOAD: begin
        if (load_bad) begin
          result.status = ST_INVALID;
        end else begin
          result.year  = item.year;
          result.month = item.month;
          result.day   = item.day;
          result.leap  = leap_load;
        end
      end
      OP_NEXT: begin
        if (cur_day >= len_cur) begin
          result.day = DAY_MIN;
          if (cur_month >= MONTH_MAX) begin
            result.month = MONTH_MIN;
            result.year  = year_inc;
            result.leap  = leap_inc;
            if (cur_year >= YEAR_MAX) begin
              result.status = ST_WRAP;
            end
          end else begin
            result.month = cur_month + 4'd1;
          end
        end else begin
          result.day = cur_day + 5'd1;
        end
      end
      OP_PREV: begin
        if (cur_day <= DAY_MIN) begin
          if (cur_month <= MONTH_MIN) begin
            result.month = MONTH_MAX;
            result.day   = DAY_MAX;
            result.year  = year_dec;
            result.leap  = leap_dec;
            if (cur_year == 14'd0) begin
              result.status = ST_WRAP;
            end
          end else begin
            result.month = month_prev;
            result.day   = len_prev;
          end
        end else begin
          result.day = cur_day - 5'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // Year zero counts as a leap year, so the reset leap bit is set.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_year  <= 14'd0;
      cur_month <= MONTH_MIN;
      cur_day   <= DAY_MIN;
      cur_leap  <= 1'b1;
    end else if (step) begin
      cur_year  <= result.year;
      cur_month <= result.month;
      cur_day   <= result.day;
      cur_leap  <= result.leap;
    end
  end

endmodule

>>> sv/calendar_date_up_down_counter_unit.sv
// Top level of the Gregorian calendar date up/down counter.
// Depends on caldate_pkg, caldate_if, caldate_in_reg and caldate_core.
//
// Usage:
//   cmd carries one command per transfer: query, load a date, next day or
//   previous day, with the load fields used only by a load. result returns
//   exactly one item per command: the held date after the command, the
//   leap-year flag of that year, and a status (ok, year wrapped between
//   9999 and 0, or load rejected as an invalid date; a rejected load keeps
//   the held date).
//   Path: an accepted command is captured in the input register; once the
//   result register is free or drains, it updates the held date and lands
//   in the result register, where result.valid then shows its result.
//   Throughput: one command per cycle while result.ready is high; the date
//   update is a single pass of compare/increment logic plus three parallel
//   leap-year checks (the year plus one, minus one, and the load year)
//   between the input register and the result register.
//   Stall: while result.ready is low the result register holds its item,
//   the input register still takes one more command, and cmd.ready drops
//   only once both registers are full.
//   Reset (rst, synchronous): both stages empty, held date 0000-01-01.
module calendar_date_up_down_counter_unit
  import caldate_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  caldate_in_if.sink    cmd,
  caldate_out_if.source result
);

  caldate_item_t   item;
  logic            item_valid;
  logic            take;
  caldate_result_t step_res;

  logic            res_valid;
  caldate_result_t res_data;

  // Advance the held command whenever the result register is free or drains now.
  assign take = item_valid && (!res_valid || result.ready);

  caldate_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  caldate_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (take),
    .item   (item),
    .result (step_res)
  );

  // Result register: hold until transferred, refill in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_data <= step_res;
    end
  end

  assign result.valid     = res_valid;
  assign result.out_year  = res_data.year;
  assign result.out_month = res_data.month;
  assign result.out_day   = res_data.day;
  assign result.leap_flag = res_data.leap;
  assign result.status    = res_data.status;

endmodule

>>> test/tb_calendar_date_up_down_counter_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for calendar_date_up_down_counter_unit.
// Depends on caldate_pkg, caldate_if and the RTL; runs directed edge dates
// first, then random load-and-step sequences under bursty traffic and stalls.
module tb_calendar_date_up_down_counter_unit;
  import caldate_pkg::*;

  localparam int RANDOM_COMMANDS = 1800;
  localparam int WATCHDOG_LIMIT  = 2000;  // cycles with no transfer on either side
  localparam int REPORT_LIMIT    = 10;
  localparam int DRAIN_CYCLES    = 4;     // two-stage pipe plus margin
  localparam int HOLD_OFF_CYCLES = 80;

  // Tracks the held date, predicts one result per command and keeps the
  // results still owed by the block in arrival order.
  class calendar_tracker;
    int unsigned     yr;
    int unsigned     mo;
    int unsigned     dy;
    caldate_result_t expected_dates[$];
    int              failures;
    int              op_count[4];
    int              status_count[4];

    function new();
      yr = 0;
      mo = MONTH_MIN;
      dy = DAY_MIN;
      failures = 0;
      foreach (op_count[i]) op_count[i] = 0;
      foreach (status_count[i]) status_count[i] = 0;
    endfunction

    function bit leap_year(int unsigned y);
      return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function int unsigned days_in(int unsigned y, int unsigned m);
      case (m)
        1, 3, 5, 7, 8, 10, 12: return 31;
        4, 6, 9, 11:           return 30;
        2:                     return leap_year(y) ? 29 : 28;
        default:               return 0;
      endcase
    endfunction

    // Advance the held date by one accepted command and queue its result.
    function void note_command(caldate_item_t c);
      int unsigned     len;
      caldate_status_t st;
      caldate_result_t r;
      st = ST_OK;
      case (c.op)
        OP_LOAD: begin
          len = days_in(c.year, c.month);
          if (c.year > YEAR_MAX || len == 0 || c.day == 0 || c.day > len) begin
            st = ST_INVALID;
          end else begin
            yr = c.year;
            mo = c.month;
            dy = c.day;
          end
        end
        OP_NEXT: begin
          if (dy >= days_in(yr, mo)) begin
            dy = DAY_MIN;
            if (mo >= MONTH_MAX) begin
              mo = MONTH_MIN;
              if (yr >= YEAR_MAX) begin
                yr = 0;
                st = ST_WRAP;
              end else begin
                yr++;
              end
            end else begin
              mo++;
            end
          end else begin
            dy++;
          end
        end
        OP_PREV: begin
          if (dy <= DAY_MIN) begin
            if (mo <= MONTH_MIN) begin
              mo = MONTH_MAX;
              dy = DAY_MAX;
              if (yr == 0) begin
                yr = YEAR_MAX;
                st = ST_WRAP;
              end else begin
                yr--;
              end
            end else begin
              mo--;
              dy = days_in(yr, mo);
            end
          end else begin
            dy--;
          end
        end
        default: ;
      endcase
      r.year   = 14'(yr);
      r.month  = 4'(mo);
      r.day    = 5'(dy);
      r.leap   = leap_year(yr);
      r.status = st;
      expected_dates.push_back(r);
      op_count[c.op]++;
      status_count[st]++;
    endfunction

    // Compare one delivered result against the oldest owed one.
    function void check_result(caldate_result_t got);
      caldate_result_t want;
      if (expected_dates.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("unexpected result %0d-%0d-%0d leap %0b status %0d",
                   got.year, got.month, got.day, got.leap, got.status);
        return;
      end
      want = expected_dates.pop_front();
      if (got.year !== want.year || got.month !== want.month || got.day !== want.day ||
          got.leap !== want.leap || got.status !== want.status) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("result mismatch: expected %0d-%0d-%0d leap %0b status %0d",
                   want.year, want.month, want.day, want.leap, want.status);
          $display("                 got      %0d-%0d-%0d leap %0b status %0d",
                   got.year, got.month, got.day, got.leap, got.status);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  caldate_in_if  cmd_ch();
  caldate_out_if res_ch();

  calendar_date_up_down_counter_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd_ch),
    .result (res_ch)
  );

  calendar_tracker tracker = new();

  int          commands_sent    = 0;
  int          burst_left       = 0;
  bit          gap_free         = 1'b0;
  int unsigned hold_off_request = 0;
  int          idle_cycles      = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Drive every input to a known value from time zero, with reset asserted.
  initial begin
    rst               <= 1'b1;
    cmd_ch.valid      <= 1'b0;
    cmd_ch.operation  <= OP_QUERY;
    cmd_ch.load_year  <= '0;
    cmd_ch.load_month <= '0;
    cmd_ch.load_day   <= '0;
  end

  // Receiver: play a random 16-bit ready pattern that is redrawn whenever a
  // random phase ends (all-ones now and then), and obey a hold-off request by
  // dropping ready for the requested hold-off.
  initial begin
    int unsigned phase_left;
    int unsigned hold_left;
    int unsigned bit_idx;
    logic [15:0] pattern;
    phase_left = 0;
    hold_left  = 0;
    bit_idx    = 0;
    pattern    = 16'hffff;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_request != 0) begin
        hold_left        = hold_off_request;
        hold_off_request = 0;
      end
      if (phase_left == 0) begin
        phase_left = $urandom_range(50, 300);
        pattern    = ($urandom_range(0, 3) == 0) ? 16'hffff : (16'($urandom) | 16'h0001);
      end
      phase_left--;
      if (hold_left != 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= pattern[bit_idx];
      end
      bit_idx = (bit_idx + 1) % 16;
    end
  end

  // Check every result transfer; values are the ones held before the edge.
  always @(posedge clk) begin : result_monitor
    caldate_result_t seen;
    if (!rst && res_ch.valid && res_ch.ready) begin
      seen.year   = res_ch.out_year;
      seen.month  = res_ch.out_month;
      seen.day    = res_ch.out_day;
      seen.leap   = res_ch.leap_flag;
      seen.status = caldate_status_t'(res_ch.status);
      tracker.check_result(seen);
    end
  end

  // Abort when neither side has moved a transfer for too long.
  always @(posedge clk) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               idle_cycles, tracker.expected_dates.size());
      $display("calendar_date_up_down_counter_unit test failed");
      $finish;
    end
  end

  function automatic caldate_item_t make_cmd(caldate_op_t op, int unsigned y,
                                             int unsigned m, int unsigned d);
    caldate_item_t c;
    c.op    = op;
    c.year  = 14'(y);
    c.month = 4'(m);
    c.day   = 5'(d);
    return c;
  endfunction

  // Fill the load fields with raw random bits; the block must ignore them
  // unless the command is a load.
  function automatic caldate_item_t noisy_cmd(caldate_op_t op);
    return make_cmd(op, $urandom, $urandom, $urandom);
  endfunction

  // Offer one command and wait for its transfer. Open a random gap between
  // bursts unless the current stretch runs without idling.
  task automatic send_command(caldate_item_t c);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      if (!gap_free) begin
        cmd_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    burst_left--;
    cmd_ch.valid      <= 1'b1;
    cmd_ch.operation  <= c.op;
    cmd_ch.load_year  <= c.year;
    cmd_ch.load_month <= c.month;
    cmd_ch.load_day   <= c.day;
    do @(posedge clk); while (!cmd_ch.ready);
    tracker.note_command(c);
    commands_sent++;
  endtask

  // Stop offering and wait until every owed result has been delivered.
  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (tracker.expected_dates.size() != 0);
  endtask

  // One well-formed sequence: load a date, often near an interesting boundary,
  // then walk it mostly in one direction, with queries, backsteps and stray
  // loads mixed in. Some anchors are raw bits to exercise rejection.
  task automatic run_sequence();
    caldate_item_t anchor;
    caldate_item_t step_cmd;
    int unsigned   pick;
    int unsigned   len;
    int unsigned   r;
    int            steps;
    bit            forward;
    caldate_op_t   fwd_op;
    caldate_op_t   back_op;
    pick = $urandom_range(0, 9);
    anchor.op = OP_LOAD;
    case (pick)
      0, 1: begin
        // Year range ends, to reach both wraps.
        if ($urandom_range(0, 1)) begin
          anchor.year  = 14'(YEAR_MAX - $urandom_range(0, 2));
          anchor.month = MONTH_MAX;
        end else begin
          anchor.year  = 14'($urandom_range(0, 2));
          anchor.month = MONTH_MIN;
        end
      end
      2, 3: begin
        // Century years around February, where the 100/400 rule bites.
        anchor.year  = 14'(100 * $urandom_range(0, 99));
        anchor.month = 4'($urandom_range(2, 3));
      end
      default: begin
        anchor.year  = 14'($urandom_range(0, YEAR_MAX));
        anchor.month = 4'($urandom_range(MONTH_MIN, MONTH_MAX));
      end
    endcase
    len = tracker.days_in(anchor.year, anchor.month);
    case ($urandom_range(0, 2))
      0:       anchor.day = 5'(len - $urandom_range(0, 2));
      1:       anchor.day = 5'($urandom_range(1, 3));
      default: anchor.day = 5'($urandom_range(1, len));
    endcase
    if (pick >= 8) anchor = noisy_cmd(OP_LOAD);
    send_command(anchor);

    forward = $urandom_range(0, 1);
    fwd_op  = forward ? OP_NEXT : OP_PREV;
    back_op = forward ? OP_PREV : OP_NEXT;
    steps   = $urandom_range(1, 40);
    repeat (steps) begin
      r = $urandom_range(0, 19);
      if (r == 0)      step_cmd = noisy_cmd(OP_QUERY);
      else if (r == 1) step_cmd = noisy_cmd(OP_LOAD);
      else if (r <= 3) step_cmd = noisy_cmd(back_op);
      else             step_cmd = noisy_cmd(fwd_op);
      send_command(step_cmd);
    end
  endtask

  initial begin
    caldate_item_t directed_cmds[$];
    int            seq_count;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset date, both wraps, rejected loads of every kind
    // (year, month, day zero, day past month end, Feb 29 in common and
    // century years, all-ones fields), leap Feb in year zero and 2000,
    // non-leap century 2100, month and year rollover both ways.
    directed_cmds.push_back(make_cmd(OP_QUERY, 16383, 15, 31));
    directed_cmds.push_back(make_cmd(OP_PREV, 0, 0, 0));
    directed_cmds.push_back(make_cmd(OP_NEXT, 0, 0, 0));
    directed_cmds.push_back(make_cmd(OP_LOAD, 16383, 15, 31));
    directed_cmds.push_back(make_cmd(OP_LOAD, 10000, 1, 1));
    directed_cmds.push_back(make_cmd(OP_LOAD, 2024, 0, 10));
    directed_cmds.push_back(make_cmd(OP_LOAD, 2024, 13, 1));
    directed_cmds.push_back(make_cmd(OP_LOAD, 2024, 5, 0));
    directed_cmds.push_back(make_cmd(OP_LOAD, 2023, 4, 31));
    directed_cmds.push_back(make_cmd(OP_LOAD, 1900, 2, 29));
    directed_cmds.push_back(make_cmd(OP_LOAD, 2023, 2, 29));
    directed_cmds.push_back(make_cmd(OP_LOAD, 0, 0, 0));
    directed_cmds.push_back(make_cmd(OP_LOAD, 2000, 2, 29));
    directed_cmds.push_back(make_cmd(OP_NEXT, 0, 0, 0));
    directed_cmds.push_back(make_cmd(OP_PREV, 0, 0, 0));
    directed_cmds.push_back(make_cmd(OP_LOAD, 2100, 3, 1));
    directed_cmds.push_back(make_cmd(OP_PREV, 0, 0, 0));
    directed_cmds.push_back(make_cmd(OP_LOAD, 0, 2, 28));
    directed_cmds.push_back(make_cmd(OP_NEXT, 0, 0, 0));
    directed_cmds.push_back(make_cmd(OP_NEXT, 0, 0, 0));
    directed_cmds.push_back(make_cmd(OP_LOAD, 9999, 12, 31));
    directed_cmds.push_back(make_cmd(OP_NEXT, 0, 0, 0));
    directed_cmds.push_back(make_cmd(OP_LOAD, 2024, 4, 30));
    directed_cmds.push_back(make_cmd(OP_NEXT, 0, 0, 0));
    directed_cmds.push_back(make_cmd(OP_LOAD, 2024, 12, 31));
    directed_cmds.push_back(make_cmd(OP_NEXT, 0, 0, 0));
    directed_cmds.push_back(make_cmd(OP_PREV, 0, 0, 0));
    foreach (directed_cmds[i]) send_command(directed_cmds[i]);
    drain_results();

    // Random: mix gapped and gap-free stretches; now and then stall
    // the receiver long enough to back the pipe up, and after the next
    // sequence let every owed result come home before going on.
    seq_count = 0;
    while (commands_sent < RANDOM_COMMANDS + directed_cmds.size()) begin
      gap_free = ($urandom_range(0, 3) == 0);
      if (seq_count % 30 == 10) begin
        hold_off_request = HOLD_OFF_CYCLES;
        gap_free         = 1'b1;
      end
      run_sequence();
      if (seq_count % 30 == 11) drain_results();
      seq_count++;
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d commands: %0d queries, %0d loads, %0d next-day, %0d previous-day",
             commands_sent, tracker.op_count[OP_QUERY], tracker.op_count[OP_LOAD],
             tracker.op_count[OP_NEXT], tracker.op_count[OP_PREV]);
    $display("saw %0d rejected loads and %0d year wraps; %0d mismatches",
             tracker.status_count[ST_INVALID], tracker.status_count[ST_WRAP],
             tracker.failures);
    if (tracker.failures == 0 && tracker.expected_dates.size() == 0) begin
      $display("calendar_date_up_down_counter_unit test passed");
    end else begin
      $display("calendar_date_up_down_counter_unit test failed");
    end
    $finish;
  end

endmodule

>>> calendar_date_up_down_counter_unit.f
sv/caldate_pkg.sv
sv/caldate_if.sv
sv/caldate_in_reg.sv
sv/caldate_core.sv
sv/calendar_date_up_down_counter_unit.sv
test/tb_calendar_date_up_down_counter_unit.sv
